FILE: hw/rtl/scx_pkg.sv
// ----------------------------------------------------------------------------
// scx_pkg: shared types and constants for the stereo center extractor
// Widths of the sample path, root and divide chains.
// ----------------------------------------------------------------------------
package scx_pkg;
	localparam int SampleBits = 24;
	localparam int FracBits   = 16;
	localparam int OutBits    = SampleBits + 1;
	localparam int PowBits    = 2 * SampleBits + 1;
	localparam int MagBits    = SampleBits + 1;
	localparam int SumBits    = MagBits + 1;
	localparam int FacBits    = FracBits + 2;
	localparam int SqrtSteps  = (PowBits + 1) / 2;
	localparam int DivSteps   = FracBits + 2;

	typedef struct packed {
		logic signed [SampleBits-1:0] lr;
		logic signed [SampleBits-1:0] li;
		logic signed [SampleBits-1:0] rr;
		logic signed [SampleBits-1:0] ri;
		logic                         last;
	} smp_t;

	// restoring root state: remainder, root, remaining radicand bits
	typedef struct packed {
		logic [MagBits:0]   rem;
		logic [MagBits-1:0] root;
		logic [PowBits:0]   rad;
	} sqst_t;

	// restoring divide state
	typedef struct packed {
		logic [SumBits:0]   rem;
		logic [SumBits-1:0] den;
		logic [FacBits-1:0] quo;
		logic               zero;
	} dvst_t;
endpackage

FILE: hw/rtl/stereo_center_extract_bin.sv
// ----------------------------------------------------------------------------
// stereo_center_extract_bin: center/side split of one stereo STFT bin
// Request to result: a power-sum stage, then the row described below.
// Throughput: one request per cycle; a row of root cells, then divide cells,
// then a multiply stage and an output stage, all advancing together.
// The row stalls as a whole only when the output register is held.
// Reset clears valid bits only.
// ----------------------------------------------------------------------------
module stereo_center_extract_bin import scx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	output logic ready_in,
	input  logic signed [SampleBits-1:0] left_real,
	input  logic signed [SampleBits-1:0] left_imag,
	input  logic signed [SampleBits-1:0] right_real,
	input  logic signed [SampleBits-1:0] right_imag,
	input  logic last_bin,
	output logic valid_out,
	input  logic ready_out,
	output logic signed [OutBits-1:0] center_real,
	output logic signed [OutBits-1:0] center_imag,
	output logic signed [OutBits-1:0] left_side_real,
	output logic signed [OutBits-1:0] left_side_imag,
	output logic signed [OutBits-1:0] right_side_real,
	output logic signed [OutBits-1:0] right_side_imag,
	output logic frame_end
);
	logic en;
	assign en = !valid_out || ready_out;
	assign ready_in = en;

	// stage 1: power sums
	logic v_s1;
	smp_t d_s1;
	logic [PowBits-1:0] pl_s1, pr_s1;
	logic signed [2*SampleBits-1:0] sq_lr, sq_li, sq_rr, sq_ri;
	assign sq_lr = left_real * left_real;
	assign sq_li = left_imag * left_imag;
	assign sq_rr = right_real * right_real;
	assign sq_ri = right_imag * right_imag;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= valid_in;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= '{left_real, left_imag, right_real, right_imag, last_bin};
			pl_s1 <= {1'b0, sq_lr} + {1'b0, sq_li};
			pr_s1 <= {1'b0, sq_rr} + {1'b0, sq_ri};
		end
	end

	// root chain
	logic  sv [SqrtSteps+1];
	sqst_t sl [SqrtSteps+1];
	sqst_t sr [SqrtSteps+1];
	smp_t  sd [SqrtSteps+1];
	assign sv[0] = v_s1;
	assign sd[0] = d_s1;
	assign sl[0] = '{rem: '0, root: '0, rad: {1'b0, pl_s1}};
	assign sr[0] = '{rem: '0, root: '0, rad: {1'b0, pr_s1}};
	for (genvar i = 0; i < SqrtSteps; i++) begin : g_sq
		scx_sqrt_cell u_cell (
			.clk, .arst_n, .en, .vin(sv[i]), .l_in(sl[i]), .r_in(sr[i]), .d_in(sd[i]),
			.vout(sv[i+1]), .l_out(sl[i+1]), .r_out(sr[i+1]), .d_out(sd[i+1])
		);
	end

	logic [MagBits-1:0] ml, mr, mn;
	assign ml = sl[SqrtSteps].root;
	assign mr = sr[SqrtSteps].root;
	assign mn = (ml < mr) ? ml : mr;

	// divide chain: (mn << (FracBits+2)) / (ml+mr); quotient bits FracBits+1..0
	logic  dv [DivSteps+1];
	dvst_t dq [DivSteps+1];
	smp_t  dd [DivSteps+1];
	assign dv[0] = sv[SqrtSteps];
	assign dd[0] = sd[SqrtSteps];
	assign dq[0] = '{rem: (SumBits+1)'(mn), den: SumBits'(ml) + SumBits'(mr),
		quo: '0, zero: (ml == '0) || (mr == '0)};
	// every step doubles first: mn < den, so quotient is bit-wise from mn*2
	for (genvar i = 0; i < DivSteps; i++) begin : g_dv
		scx_div_cell u_cell (
			.clk, .arst_n, .en, .vin(dv[i]), .q_in(dq[i]), .d_in(dd[i]),
			.vout(dv[i+1]), .q_out(dq[i+1]), .d_out(dd[i+1])
		);
	end

	// quotient of mn*2^DivSteps/den = factor*2 ... shift back by one bit
	logic [FacBits-1:0] fac;
	smp_t de;
	assign de  = dd[DivSteps];
	assign fac = dq[DivSteps].zero ? '0 : {1'b0, dq[DivSteps].quo[FacBits-1:1]};

	// multiply stage
	localparam int PBits = FacBits + SampleBits + 2;
	logic v_m;
	smp_t d_m;
	logic signed [PBits-1:0] pre_m, pim_m;
	logic signed [FacBits:0] fac_sg;
	logic signed [OutBits-1:0] sum_re, sum_im;
	assign fac_sg = {1'b0, fac};
	assign sum_re = {de.lr[SampleBits-1], de.lr} + {de.rr[SampleBits-1], de.rr};
	assign sum_im = {de.li[SampleBits-1], de.li} + {de.ri[SampleBits-1], de.ri};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m <= 1'b0;
		else if (en) v_m <= dv[DivSteps];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_m   <= de;
			pre_m <= fac_sg * sum_re;
			pim_m <= fac_sg * sum_im;
		end
	end

	logic signed [OutBits-1:0] cr, ci;
	assign cr = OutBits'(pre_m >>> (FracBits + 1));
	assign ci = OutBits'(pim_m >>> (FracBits + 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (en) valid_out <= v_m;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			center_real     <= cr;
			center_imag     <= ci;
			left_side_real  <= {d_m.lr[SampleBits-1], d_m.lr} - cr;
			left_side_imag  <= {d_m.li[SampleBits-1], d_m.li} - ci;
			right_side_real <= {d_m.rr[SampleBits-1], d_m.rr} - cr;
			right_side_imag <= {d_m.ri[SampleBits-1], d_m.ri} - ci;
			frame_end       <= d_m.last;
		end
	end

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ready_in == (!valid_out || ready_out)) else $error("ready mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && !ready_out |=> valid_out && $stable(center_real))
		else $error("result dropped");
	a_fac: assert property (@(posedge clk) disable iff (!arst_n)
		dv[DivSteps] |-> fac <= FacBits'(1 << FracBits)) else $error("factor above half");
endmodule

FILE: hw/rtl/scx_sqrt_cell.sv
// ----------------------------------------------------------------------------
// scx_sqrt_cell: one root digit for both channels
// Produces one result bit per cell, registered, samples carried along.
// ----------------------------------------------------------------------------
module scx_sqrt_cell import scx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vin,
	input  sqst_t l_in,
	input  sqst_t r_in,
	input  smp_t  d_in,
	output logic  vout,
	output sqst_t l_out,
	output sqst_t r_out,
	output smp_t  d_out
);
	function automatic sqst_t step(input sqst_t s);
		sqst_t o;
		logic [MagBits+2:0] t;
		logic [MagBits+2:0] trial;
		t     = {s.rem, s.rad[PowBits:PowBits-1]};
		trial = {1'b0, s.root, 2'b01};
		o.rad = {s.rad[PowBits-2:0], 2'b00};
		if (t >= trial) begin
			o.rem  = (MagBits+1)'(t - trial);
			o.root = {s.root[MagBits-2:0], 1'b1};
		end else begin
			o.rem  = t[MagBits:0];
			o.root = {s.root[MagBits-2:0], 1'b0};
		end
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			l_out <= step(l_in);
			r_out <= step(r_in);
			d_out <= d_in;
		end
	end
endmodule

FILE: hw/rtl/scx_div_cell.sv
// ----------------------------------------------------------------------------
// scx_div_cell: one quotient bit of min/(mL+mR)
// Restoring divide step, registered, samples carried along.
// ----------------------------------------------------------------------------
module scx_div_cell import scx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vin,
	input  dvst_t q_in,
	input  smp_t  d_in,
	output logic  vout,
	output dvst_t q_out,
	output smp_t  d_out
);
	dvst_t nx;
	logic [SumBits+1:0] t;
	always_comb begin
		t = {q_in.rem, 1'b0};
		nx = q_in;
		if (t >= {2'b00, q_in.den}) begin
			nx.rem = (SumBits+1)'(t - {2'b00, q_in.den});
			nx.quo = {q_in.quo[FacBits-2:0], 1'b1};
		end else begin
			nx.rem = t[SumBits:0];
			nx.quo = {q_in.quo[FacBits-2:0], 1'b0};
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q_out <= nx;
			d_out <= d_in;
		end
	end
endmodule
